>>> rtl/core/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants for the FNV-1a double-hashing Bloom filter core.
// ----------------------------------------------------------------------------
package bfd_pkg;

   localparam int unsigned MAX_BITS_DEF   = 65536;
   localparam int unsigned MAX_HASHES_DEF = 16;

   localparam int unsigned FILTER_BITS_W = 17;
   localparam int unsigned HASH_COUNT_W  = 5;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned COUNT_W       = 32;

   localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = 17'd65536;
   localparam logic [HASH_COUNT_W-1:0]  HASH_COUNT_RST  = 5'd7;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_COUNT  = 2'd1;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_CHECK = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // FNV-1a 64: prime = 2^40 + 0x1B3
   localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
   localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
   localparam int unsigned FNV_PRIME_SH = 40;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_PROBE,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/core/bfd_ram.sv
// ----------------------------------------------------------------------------
// bfd_ram
// Generic single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bfd_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/bloom_filter_fnv_double_hash_core.sv
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash_core
// Bloom filter over byte-serial keys, FNV-1a 64 digest split for double hashing.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  request   req_mode req_key_byte req_byte_valid     start & !busy
//            req_last
//  response  rsp_present rsp_op_done                  rsp_strobe (one cycle)
//            rsp_inserted_count
//  csr       csr_index csr_write_data                 csr_write_enable
//
//  Key bytes: one per cycle while busy is low. After the last add/check byte, the
//  bit-serial remainder unit (h1 mod m, h2 mod m) runs, then k probes go to the
//  bit store port, then a finish state. Clear: one store entry per cycle, every
//  entry. After reset the same clearing pass runs with busy high. The response
//  side has no back-pressure; each result shows for one cycle.
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash_core #(
   parameter int unsigned MAX_BITS   = bfd_pkg::MAX_BITS_DEF,
   parameter int unsigned MAX_HASHES = bfd_pkg::MAX_HASHES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic [7:0]                        req_key_byte,
   input  logic                              req_byte_valid,
   input  logic                              req_last,
   output logic                              rsp_strobe,
   output logic                              rsp_present,
   output logic [1:0]                        rsp_op_done,
   output logic [bfd_pkg::COUNT_W-1:0]       rsp_inserted_count,
   input  logic                              csr_write_enable,
   input  logic [bfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfd_pkg::FILTER_BITS_W-1:0] csr_write_data
);

   localparam int unsigned AW = $clog2(MAX_BITS);
   localparam int unsigned MW = $clog2(MAX_BITS + 1);
   localparam int unsigned CW = (MW > bfd_pkg::FILTER_BITS_W) ? MW : bfd_pkg::FILTER_BITS_W;
   localparam int unsigned KW = $clog2(MAX_HASHES + 1);

   bfd_pkg::state_type state_ff, state_in;

   logic [bfd_pkg::FILTER_BITS_W-1:0] filter_bits_ff;
   logic [bfd_pkg::HASH_COUNT_W-1:0]  hash_count_ff;

   logic [63:0]                  accum_ff, accum_in;
   logic [31:0]                  h1_ff, h1_in, h2_ff, h2_in;
   logic [MW-1:0]                r1_ff, r1_in, r2_ff, r2_in;
   logic [MW-1:0]                m_ff, m_in;
   logic [KW-1:0]                k_ff, k_in;
   logic [4:0]                   div_cnt_ff, div_cnt_in;
   logic [1:0]                   op_ff, op_in;
   logic                         hit_ff, hit_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [AW-1:0]                clr_addr_ff, clr_addr_in;
   logic                         clr_op_ff, clr_op_in;
   logic [bfd_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic                         rsp_present_ff, rsp_present_in;
   logic [1:0]                   rsp_op_ff, rsp_op_in;
   logic [bfd_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic          accept;
   logic [63:0]   fold_x, fold_val, digest;
   logic [CW-1:0] fb_ext;
   logic [MW-1:0] m_eff;
   logic [KW-1:0] k_eff;
   logic [MW:0]   t1, t2;
   logic [MW:0]   psum;
   logic          div_end, probe_end, clr_end, hit_final;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [0:0]    mem_wdata, mem_rdata;

   assign accept = start && !busy;

   // FNV-1a step: xor, then multiply by 2^40 + 0x1B3
   assign fold_x   = accum_ff ^ {56'd0, req_key_byte};
   assign fold_val = (fold_x << bfd_pkg::FNV_PRIME_SH) + (fold_x * 64'(bfd_pkg::FNV_PRIME_LO));
   assign digest   = req_byte_valid ? fold_val : accum_ff;

   always_comb begin
      fb_ext = CW'(filter_bits_ff);
      if (fb_ext < CW'(8)) begin
         m_eff = MW'(8);
      end else if (fb_ext > CW'(MAX_BITS)) begin
         m_eff = MW'(MAX_BITS);
      end else begin
         m_eff = MW'(fb_ext);
      end
      if (hash_count_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(hash_count_ff) > 32'(MAX_HASHES)) begin
         k_eff = KW'(MAX_HASHES);
      end else begin
         k_eff = KW'(hash_count_ff);
      end
   end

   assign t1        = {r1_ff, h1_ff[31]};
   assign t2        = {r2_ff, h2_ff[31]};
   assign psum      = {1'b0, r1_ff} + {1'b0, r2_ff};
   assign div_end   = (div_cnt_ff == '0);
   assign probe_end = (k_ff == KW'(1));
   assign clr_end   = (clr_addr_ff == AW'(MAX_BITS - 1));
   assign hit_final = hit_ff && (!rd_pend_ff || mem_rdata[0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfd_pkg::ST_CLEAR: begin
            if (clr_end) state_in = bfd_pkg::ST_IDLE;
         end
         bfd_pkg::ST_IDLE: begin
            if (accept && req_last) begin
               if (req_mode == bfd_pkg::MODE_CLEAR) begin
                  state_in = bfd_pkg::ST_CLEAR;
               end else if (req_mode == bfd_pkg::MODE_ADD || req_mode == bfd_pkg::MODE_CHECK) begin
                  state_in = bfd_pkg::ST_DIV;
               end
            end
         end
         bfd_pkg::ST_DIV: begin
            if (div_end) state_in = bfd_pkg::ST_PROBE;
         end
         bfd_pkg::ST_PROBE: begin
            if (probe_end) state_in = bfd_pkg::ST_FINISH;
         end
         bfd_pkg::ST_FINISH: state_in = bfd_pkg::ST_IDLE;
         default: state_in = bfd_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy      = 1'b1;
      mem_we    = 1'b0;
      mem_addr  = r1_ff[AW-1:0];
      mem_wdata = 1'b0;
      case (state_ff)
         bfd_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_ff;
         end
         bfd_pkg::ST_IDLE: busy = 1'b0;
         bfd_pkg::ST_PROBE: begin
            mem_we    = (op_ff == bfd_pkg::MODE_ADD);
            mem_wdata = 1'b1;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      accum_in       = accum_ff;
      h1_in          = h1_ff;
      h2_in          = h2_ff;
      r1_in          = r1_ff;
      r2_in          = r2_ff;
      m_in           = m_ff;
      k_in           = k_ff;
      div_cnt_in     = div_cnt_ff;
      op_in          = op_ff;
      hit_in         = rd_pend_ff ? (hit_ff & mem_rdata[0]) : hit_ff;
      rd_pend_in     = 1'b0;
      clr_addr_in    = clr_addr_ff;
      clr_op_in      = clr_op_ff;
      count_in       = count_ff;
      rsp_strobe_in  = 1'b0;
      rsp_present_in = rsp_present_ff;
      rsp_op_in      = rsp_op_ff;
      rsp_count_in   = rsp_count_ff;
      case (state_ff)
         bfd_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_end) begin
               clr_op_in = 1'b0;
               if (clr_op_ff) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_present_in = 1'b0;
                  rsp_op_in      = bfd_pkg::MODE_CLEAR;
                  rsp_count_in   = '0;
               end
            end
         end
         bfd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == bfd_pkg::MODE_CLEAR) begin
                  if (req_last) begin
                     accum_in    = bfd_pkg::FNV_BASIS;
                     count_in    = '0;
                     clr_addr_in = '0;
                     clr_op_in   = 1'b1;
                  end
               end else if (req_mode == bfd_pkg::MODE_ADD || req_mode == bfd_pkg::MODE_CHECK) begin
                  accum_in = digest;
                  if (req_last) begin
                     accum_in   = bfd_pkg::FNV_BASIS;
                     h1_in      = digest[31:0];
                     h2_in      = digest[63:32];
                     r1_in      = '0;
                     r2_in      = '0;
                     m_in       = m_eff;
                     k_in       = k_eff;
                     div_cnt_in = 5'd31;
                     op_in      = req_mode;
                     hit_in     = 1'b1;
                  end
               end
            end
         end
         bfd_pkg::ST_DIV: begin
            // one remainder bit per cycle for both halves
            r1_in      = (t1 >= {1'b0, m_ff}) ? MW'(t1 - {1'b0, m_ff}) : MW'(t1);
            r2_in      = (t2 >= {1'b0, m_ff}) ? MW'(t2 - {1'b0, m_ff}) : MW'(t2);
            h1_in      = h1_ff << 1;
            h2_in      = h2_ff << 1;
            div_cnt_in = div_cnt_ff - 5'd1;
         end
         bfd_pkg::ST_PROBE: begin
            // r1 walks the probe positions, r2 holds the step (h2 mod m)
            r1_in      = (psum >= {1'b0, m_ff}) ? MW'(psum - {1'b0, m_ff}) : MW'(psum);
            k_in       = k_ff - KW'(1);
            rd_pend_in = (op_ff == bfd_pkg::MODE_CHECK);
         end
         bfd_pkg::ST_FINISH: begin
            if (op_ff == bfd_pkg::MODE_ADD && count_ff != '1) begin
               count_in = count_ff + 32'd1;
            end
            rsp_strobe_in  = 1'b1;
            rsp_present_in = (op_ff == bfd_pkg::MODE_CHECK) && hit_final;
            rsp_op_in      = op_ff;
            rsp_count_in   = (op_ff == bfd_pkg::MODE_ADD && count_ff != '1) ?
                             count_ff + 32'd1 : count_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bfd_pkg::ST_CLEAR;
         filter_bits_ff <= bfd_pkg::FILTER_BITS_RST;
         hash_count_ff  <= bfd_pkg::HASH_COUNT_RST;
         accum_ff       <= bfd_pkg::FNV_BASIS;
         count_ff       <= '0;
         clr_addr_ff    <= '0;
         clr_op_ff      <= 1'b0;
         rd_pend_ff     <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         accum_ff      <= accum_in;
         count_ff      <= count_in;
         clr_addr_ff   <= clr_addr_in;
         clr_op_ff     <= clr_op_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            case (csr_index)
               bfd_pkg::CSR_FILTER_BITS: filter_bits_ff <= csr_write_data;
               bfd_pkg::CSR_HASH_COUNT:
                  hash_count_ff <= csr_write_data[bfd_pkg::HASH_COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      h1_ff          <= h1_in;
      h2_ff          <= h2_in;
      r1_ff          <= r1_in;
      r2_ff          <= r2_in;
      m_ff           <= m_in;
      k_ff           <= k_in;
      div_cnt_ff     <= div_cnt_in;
      op_ff          <= op_in;
      hit_ff         <= hit_in;
      rsp_present_ff <= rsp_present_in;
      rsp_op_ff      <= rsp_op_in;
      rsp_count_ff   <= rsp_count_in;
   end

   bfd_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_present        = rsp_present_ff;
   assign rsp_op_done        = rsp_op_ff;
   assign rsp_inserted_count = rsp_count_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held more than one cycle");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfd_pkg::ST_PROBE) |-> (r1_ff < m_ff && r2_ff < m_ff))
      else $error("probe position or step not below m");

   a_div_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfd_pkg::ST_DIV) |-> (r1_ff < m_ff && r2_ff < m_ff))
      else $error("partial remainder not below m");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_op_done == bfd_pkg::MODE_CLEAR) |->
      (rsp_inserted_count == '0 && !rsp_present))
      else $error("clear response with nonzero count or present");

endmodule
